@@ rtl/cdlr_pkg.sv @@
// ----------------------------------------------------------------------------
// cdlr_pkg
// Shared constants, codes and control types for the circular linked ring.
// ----------------------------------------------------------------------------
package cdlr_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IN_DATA_W  = ((DATA_W + STEP_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;
    localparam int IN_USER_W  = 3;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_ROTATE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH2,
        S_ROT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    rd_walk;
        logic    push_a;
        logic    push_b;
        logic    push_commit;
        logic    pop_commit;
        logic    rot_step;
        logic    rot_commit;
        logic    out_load;
        status_t out_status;
    } cdlr_cmd_t;

    typedef struct packed {
        action_t act;
        logic    empty;
        logic    full;
        logic    steps_zero;
        logic    out_free;
    } cdlr_sts_t;

endpackage

@@ rtl/cdlr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdlr_ctrl
// Sequencer for push, pop, peek and rotate on the linked ring datapath.
// ----------------------------------------------------------------------------
module cdlr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cdlr_pkg::cdlr_sts_t sts,
    output cdlr_pkg::cdlr_cmd_t cmd
);
    import cdlr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.act == ACT_PUSH)
                begin
                    if (sts.full || sts.empty)
                    begin
                        if (sts.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_PUSH2;
                    end
                end
                else if (sts.empty)
                begin
                    if (sts.out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (sts.act == ACT_ROTATE)
                begin
                    state_next = S_ROT;
                end
                else if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PUSH2:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROT:
            begin
                if (sts.steps_zero && sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.load   = in_valid;
            end
            S_EXEC:
            begin
                if (sts.act == ACT_PUSH)
                begin
                    if (sts.full)
                    begin
                        cmd.out_load   = sts.out_free;
                        cmd.out_status = ST_FULL;
                    end
                    else if (sts.empty)
                    begin
                        cmd.push_a      = sts.out_free;
                        cmd.push_commit = sts.out_free;
                        cmd.out_load    = sts.out_free;
                    end
                    else
                    begin
                        cmd.push_a = 1'b1;
                    end
                end
                else if (sts.empty)
                begin
                    cmd.out_load   = sts.out_free;
                    cmd.out_status = ST_EMPTY;
                end
                else if (sts.act == ACT_POP)
                begin
                    cmd.pop_commit = sts.out_free;
                    cmd.out_load   = sts.out_free;
                end
                else if (sts.act == ACT_PEEK)
                begin
                    cmd.out_load = sts.out_free;
                end
            end
            S_PUSH2:
            begin
                cmd.push_b      = sts.out_free;
                cmd.push_commit = sts.out_free;
                cmd.out_load    = sts.out_free;
            end
            S_ROT:
            begin
                if (sts.steps_zero)
                begin
                    cmd.rot_commit = sts.out_free;
                    cmd.out_load   = sts.out_free;
                end
                else
                begin
                    cmd.rot_step = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_walk  = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/cdlr_dpath.sv @@
// ----------------------------------------------------------------------------
// cdlr_dpath
// Link, value and free-index memories with head, count and result registers.
// ----------------------------------------------------------------------------
module cdlr_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdlr_pkg::cdlr_cmd_t               cmd,
    output cdlr_pkg::cdlr_sts_t               sts,
    input  logic [cdlr_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [cdlr_pkg::IN_USER_W-1:0]    in_user,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cdlr_pkg::OUT_DATA_W-1:0]   out_data,
    output logic [cdlr_pkg::OUT_USER_W-1:0]   out_user
);
    import cdlr_pkg::*;

    logic [IDX_W-1:0]      next_mem [CAPACITY];
    logic [IDX_W-1:0]      prev_mem [CAPACITY];
    logic [VALUE_BITS-1:0] value_mem [CAPACITY];
    logic [IDX_W-1:0]      free_mem [CAPACITY];
    logic [CAPACITY-1:0]   free_valid_reg;

    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      head_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      top_reg;
    logic [CNT_W-1:0]      top_next;
    logic [CNT_W-1:0]      top_dec;

    action_t               act_reg;
    logic                  dir_reg;
    logic [DATA_W-1:0]     pval_reg;
    logic [STEP_W-1:0]     steps_reg;
    logic [IDX_W-1:0]      cur_reg;
    logic [IDX_W-1:0]      alloc_reg;

    logic [IDX_W-1:0]      nx_q;
    logic [IDX_W-1:0]      pv_q;
    logic [VALUE_BITS-1:0] val_q;
    logic [IDX_W-1:0]      fs_q;

    logic [IDX_W-1:0]      new_cur;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      fs_rd_addr;
    logic [IDX_W-1:0]      alloc_n;
    logic [VALUE_BITS-1:0] store_val;
    logic [63:0]           val_ext;
    logic                  release_ok;

    logic                  nx_we;
    logic [IDX_W-1:0]      nx_wa;
    logic [IDX_W-1:0]      nx_wd;
    logic                  pv_we;
    logic [IDX_W-1:0]      pv_wa;
    logic [IDX_W-1:0]      pv_wd;

    logic                  out_valid_reg;
    logic [DATA_W-1:0]     out_value_reg;
    status_t               out_status_reg;
    logic [CNT_W-1:0]      out_count_reg;
    logic [DATA_W-1:0]     rd_value;

    assign top_dec    = top_reg - CNT_W'(1);
    assign fs_rd_addr = top_dec[IDX_W-1:0];
    assign new_cur    = dir_reg ? pv_q : nx_q;
    assign rd_addr    = cmd.rd_walk ? new_cur : head_reg;
    assign alloc_n    = cmd.push_a ? fs_q : alloc_reg;
    assign store_val  = VALUE_BITS'(64'(signed'(pval_reg)));
    assign val_ext    = 64'(signed'(val_q));
    assign release_ok = (top_reg < CNT_W'(CAPACITY));

    assign sts.act        = act_reg;
    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg >= CNT_W'(CAPACITY)) || (top_reg == '0);
    assign sts.steps_zero = (steps_reg == '0);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // link write ports
    always_comb
    begin
        nx_we = 1'b0;
        nx_wa = alloc_n;
        nx_wd = alloc_n;
        pv_we = 1'b0;
        pv_wa = alloc_n;
        pv_wd = alloc_n;
        if (cmd.push_a)
        begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            if (count_reg != '0)
            begin
                nx_wd = dir_reg ? head_reg : nx_q;
                pv_wd = dir_reg ? pv_q : head_reg;
            end
        end
        else if (cmd.push_b)
        begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            nx_wa = dir_reg ? pv_q : head_reg;
            pv_wa = dir_reg ? head_reg : nx_q;
        end
        else if (cmd.pop_commit && (count_reg != CNT_W'(1)))
        begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            nx_wa = pv_q;
            nx_wd = nx_q;
            pv_wa = nx_q;
            pv_wd = pv_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (cmd.rd_en)
        begin
            nx_q <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (cmd.rd_en)
        begin
            pv_q <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_a)
        begin
            value_mem[alloc_n] <= store_val;
        end
        if (cmd.rd_en)
        begin
            val_q <= value_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop_commit && release_ok)
        begin
            free_mem[top_reg[IDX_W-1:0]] <= head_reg;
        end
        if (cmd.rd_en)
        begin
            fs_q <= free_valid_reg[fs_rd_addr] ? free_mem[fs_rd_addr]
                                               : IDX_W'(CAPACITY - 1) - fs_rd_addr;
        end
    end

    // untouched free-stack entries read as their reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_valid_reg <= '0;
        end
        else if (cmd.pop_commit && release_ok)
        begin
            free_valid_reg[top_reg[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        top_next   = top_reg;
        if (cmd.push_commit)
        begin
            head_next  = alloc_n;
            count_next = count_reg + CNT_W'(1);
            top_next   = top_dec;
        end
        else if (cmd.pop_commit)
        begin
            count_next = count_reg - CNT_W'(1);
            if (release_ok)
            begin
                top_next = top_reg + CNT_W'(1);
            end
            if (count_reg != CNT_W'(1))
            begin
                head_next = new_cur;
            end
        end
        else if (cmd.rot_commit)
        begin
            head_next = cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            top_reg   <= CNT_W'(CAPACITY);
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_PUSH;
            dir_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            act_reg <= action_t'(in_user[1:0]);
            dir_reg <= in_user[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pval_reg  <= in_data[DATA_W-1:0];
            steps_reg <= in_data[DATA_W +: STEP_W];
            cur_reg   <= head_reg;
        end
        else if (cmd.rot_step)
        begin
            steps_reg <= steps_reg - STEP_W'(1);
            cur_reg   <= new_cur;
        end
        if (cmd.push_a)
        begin
            alloc_reg <= fs_q;
        end
    end

    always_comb
    begin
        rd_value = '0;
        if ((cmd.out_status == ST_OK) && ((act_reg == ACT_POP) || (act_reg == ACT_PEEK)))
        begin
            rd_value = val_ext[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg  <= rd_value;
            out_status_reg <= cmd.out_status;
            out_count_reg  <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_DATA_W'({out_count_reg, out_value_reg});
    assign out_user  = out_status_reg;

endmodule

@@ rtl/circular_doubly_linked_ring.sv @@
// ----------------------------------------------------------------------------
// circular_doubly_linked_ring
// Pop, peek, status-only words and a push into an empty ring finish in the
// execute state; other pushes add a second link-write state; rotate
// walks one link per cycle through the link memory read port, then commits.
// One word in flight; the next is taken the cycle after the result is loaded.
// Reset is asynchronous: ring empty, head 0, free stack full, no clearing pass.
// ----------------------------------------------------------------------------
module circular_doubly_linked_ring (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] push_value, [47:32] rotate_steps
    input  logic [cdlr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action, [2] direction
    input  logic [cdlr_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] read_value, [38:32] entry_count
    output logic [cdlr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [cdlr_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import cdlr_pkg::*;

    cdlr_cmd_t cmd;
    cdlr_sts_t sts;

    cdlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cdlr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule
